FILE: rtl/core/tlbp_pkg.sv
// shared types and constants of the two-level branch predictor
// no dependencies
`timescale 1ns / 1ps

package tlbp_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = 5;
    localparam int MAX_HISTORY = 8;
    localparam int CNT_DEPTH   = MAX_ENTRIES << MAX_HISTORY;
    localparam int CNT_AW      = IDX_W + MAX_HISTORY;
    localparam int TAG_W       = 30;
    localparam int MAX_TAG     = 30;
    localparam int ADDR_W      = 5;

    localparam logic [2:0] REG_BTB_SIZE_LOG2  = 3'd0;
    localparam logic [2:0] REG_HISTORY_LENGTH = 3'd1;
    localparam logic [2:0] REG_TAG_LENGTH     = 3'd2;
    localparam logic [2:0] REG_COUNTER_INIT   = 3'd3;
    localparam logic [2:0] REG_USE_GLOBAL_HIS = 3'd4;
    localparam logic [2:0] REG_USE_GLOBAL_TAB = 3'd5;
    localparam logic [2:0] REG_SHARE_MODE     = 3'd6;

    localparam logic [1:0] SHARE_NONE = 2'd0;
    localparam logic [1:0] SHARE_PC2  = 2'd1;
    localparam logic [1:0] SHARE_PC16 = 2'd2;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    typedef struct packed {
        logic [2:0] btb_size_log2;
        logic [3:0] history_length;
        logic [4:0] tag_length;
        logic [1:0] counter_init;
        logic       use_global_history;
        logic       use_global_table;
        logic [1:0] share_mode;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic look;
        logic slice_step;
        logic read;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic is_update;
        logic global_table;
        logic sweep_last;
        logic out_busy;
    } t_dp_status;

endpackage

FILE: rtl/core/tlbp_if.sv
// request and response channel interfaces of the branch predictor
// no dependencies
`timescale 1ns / 1ps

interface tlbp_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] pc;
    logic [31:0] resolved_target;
    logic        taken;
    logic [31:0] predicted_dest;

    modport source (output valid, cmd, pc, resolved_target, taken, predicted_dest,
                    input ready);
    modport sink (input valid, cmd, pc, resolved_target, taken, predicted_dest,
                  output ready);
endinterface

interface tlbp_rsp_if;
    logic        valid;
    logic        ready;
    logic        predict_taken;
    logic [31:0] predict_target;
    logic        mispredict;

    modport source (output valid, predict_taken, predict_target, mispredict,
                    input ready);
    modport sink (input valid, predict_taken, predict_target, mispredict,
                  output ready);
endinterface

FILE: rtl/core/tlbp_cfg.sv
// apb configuration registers, raises reinit on any known register write
// depends on tlbp_pkg
`timescale 1ns / 1ps

module tlbp_cfg
    import tlbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg,
    output logic              o_reinit
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_sel;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_sel  = paddr[ADDR_W-1:2];
    assign o_reinit = w_wr && (w_sel <= REG_SHARE_MODE);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.btb_size_log2      <= 3'd0;
            r_cfg.history_length     <= 4'd1;
            r_cfg.tag_length         <= 5'd0;
            r_cfg.counter_init       <= 2'd1;
            r_cfg.use_global_history <= 1'b0;
            r_cfg.use_global_table   <= 1'b0;
            r_cfg.share_mode         <= SHARE_NONE;
        end else if (w_wr) begin
            case (w_sel)
                REG_BTB_SIZE_LOG2:  r_cfg.btb_size_log2      <= pwdata[2:0];
                REG_HISTORY_LENGTH: r_cfg.history_length     <= pwdata[3:0];
                REG_TAG_LENGTH:     r_cfg.tag_length         <= pwdata[4:0];
                REG_COUNTER_INIT:   r_cfg.counter_init       <= pwdata[1:0];
                REG_USE_GLOBAL_HIS: r_cfg.use_global_history <= pwdata[0];
                REG_USE_GLOBAL_TAB: r_cfg.use_global_table   <= pwdata[0];
                REG_SHARE_MODE:     r_cfg.share_mode         <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            REG_BTB_SIZE_LOG2:  prdata = {29'd0, r_cfg.btb_size_log2};
            REG_HISTORY_LENGTH: prdata = {28'd0, r_cfg.history_length};
            REG_TAG_LENGTH:     prdata = {27'd0, r_cfg.tag_length};
            REG_COUNTER_INIT:   prdata = {30'd0, r_cfg.counter_init};
            REG_USE_GLOBAL_HIS: prdata = {31'd0, r_cfg.use_global_history};
            REG_USE_GLOBAL_TAB: prdata = {31'd0, r_cfg.use_global_table};
            REG_SHARE_MODE:     prdata = {30'd0, r_cfg.share_mode};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/core/tlbp_ctrl.sv
// controller state machine sequencing counter clearing, lookup, slice reset and counter access
// depends on tlbp_pkg
`timescale 1ns / 1ps

module tlbp_ctrl
    import tlbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_reinit,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_SLICE = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_USE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_req_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_cmd.load = i_req_valid;
                if (i_req_valid) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                o_cmd.look = 1'b1;
                if (i_status.is_update && !i_status.hit && !i_status.global_table) begin
                    n_state = ST_SLICE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_SLICE: begin
                o_cmd.slice_step = 1'b1;
                if (i_status.sweep_last) n_state = ST_READ;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_USE;
            end
            ST_USE: begin
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
        if (i_reinit) begin
            o_cmd   = '0;
            n_state = ST_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/tlbp_dp.sv
// datapath: btb arrays, history registers, counter memory and result register
// depends on tlbp_pkg
`timescale 1ns / 1ps

module tlbp_dp
    import tlbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_reinit,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    input  logic        i_cmd_bit,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_resolved_target,
    input  logic        i_taken,
    input  logic [31:0] i_predicted_dest,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_predict_taken,
    output logic [31:0] o_predict_target,
    output logic        o_mispredict
);

    logic                    r_cmd;
    logic [31:0]             r_pc;
    logic [31:0]             r_tgt;
    logic                    r_taken;
    logic [31:0]             r_pdst;

    logic [MAX_ENTRIES-1:0]  r_valid;
    logic [TAG_W-1:0]        r_tag_mem [MAX_ENTRIES];
    logic [31:0]             r_tgt_mem [MAX_ENTRIES];
    logic [MAX_HISTORY-1:0]  r_hist [MAX_ENTRIES];
    logic [MAX_HISTORY-1:0]  r_shared;
    logic [1:0]              r_cnt_mem [CNT_DEPTH];
    logic [1:0]              r_rdata;
    logic [CNT_AW-1:0]       r_sweep;

    logic                    r_out_valid;
    logic                    r_out_taken;
    logic [31:0]             r_out_target;
    logic                    r_out_misp;

    logic [2:0]              w_l;
    logic [3:0]              w_h;
    logic [4:0]              w_tl;
    logic [IDX_W-1:0]        w_idx_mask;
    logic [IDX_W-1:0]        w_idx;
    logic [TAG_W-1:0]        w_tag_mask;
    logic [TAG_W-1:0]        w_tag;
    logic                    w_hit;
    logic [MAX_HISTORY-1:0]  w_hmask;
    logic [MAX_HISTORY-1:0]  w_hist;
    logic [MAX_HISTORY-1:0]  w_mix;
    logic [MAX_HISTORY-1:0]  w_hi;
    logic [MAX_HISTORY-1:0]  w_new_hist;
    logic [CNT_AW-1:0]       w_base;
    logic [CNT_AW-1:0]       w_ci;
    logic [CNT_AW-1:0]       w_waddr;
    logic [1:0]              w_wdata;
    logic                    w_we;
    logic [1:0]              w_step;
    logic [31:0]             w_seq;
    logic [31:0]             w_correct;
    logic                    w_pt;

    assign w_l  = (i_cfg.btb_size_log2 > 3'd5) ? 3'd5 : i_cfg.btb_size_log2;
    assign w_h  = (i_cfg.history_length == 4'd0) ? 4'd1 :
                  (i_cfg.history_length > 4'(MAX_HISTORY)) ? 4'(MAX_HISTORY) :
                  i_cfg.history_length;
    assign w_tl = (i_cfg.tag_length > 5'(MAX_TAG)) ? 5'(MAX_TAG) : i_cfg.tag_length;

    assign w_idx_mask = IDX_W'((6'd1 << w_l) - 6'd1);
    assign w_idx      = r_pc[2 +: IDX_W] & w_idx_mask;
    assign w_tag_mask = TAG_W'((31'd1 << w_tl) - 31'd1);
    assign w_tag      = TAG_W'(r_pc >> (6'd2 + 6'(w_l))) & w_tag_mask;
    assign w_hit      = r_valid[w_idx] && (r_tag_mem[w_idx] == w_tag);

    assign w_hmask = MAX_HISTORY'((9'd1 << w_h) - 9'd1);
    assign w_hist  = i_cfg.use_global_history ? r_shared : r_hist[w_idx];

    always_comb begin
        w_mix = '0;
        if (i_cfg.use_global_table) begin
            case (i_cfg.share_mode)
                SHARE_PC2:  w_mix = r_pc[2 +: MAX_HISTORY];
                SHARE_PC16: w_mix = r_pc[16 +: MAX_HISTORY];
                default:    w_mix = '0;
            endcase
        end
    end

    assign w_hi   = (w_hist ^ w_mix) & w_hmask;
    assign w_base = CNT_AW'({{MAX_HISTORY{1'b0}}, w_idx} << w_h);
    assign w_ci   = i_cfg.use_global_table ? CNT_AW'(w_hi) : (w_base | CNT_AW'(w_hi));
    assign w_new_hist = {w_hist[MAX_HISTORY-2:0], r_taken} & w_hmask;

    assign w_step = r_taken ? ((r_rdata == 2'd3) ? 2'd3 : r_rdata + 2'd1)
                            : ((r_rdata == 2'd0) ? 2'd0 : r_rdata - 2'd1);
    assign w_seq     = r_pc + 32'd4;
    assign w_correct = r_taken ? r_tgt : w_seq;
    assign w_pt      = w_hit && r_rdata[1];

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_ci;
        w_wdata = w_step;
        if (i_cmd.clear_step) begin
            w_we    = 1'b1;
            w_waddr = r_sweep;
            w_wdata = i_cfg.counter_init;
        end else if (i_cmd.slice_step) begin
            w_we    = 1'b1;
            w_waddr = w_base | CNT_AW'(r_sweep[MAX_HISTORY-1:0] & w_hmask);
            w_wdata = i_cfg.counter_init;
        end else if (i_cmd.commit && r_cmd == CMD_UPDATE) begin
            w_we = 1'b1;
        end
    end

    always_comb begin
        o_status.hit          = w_hit;
        o_status.is_update    = (r_cmd == CMD_UPDATE);
        o_status.global_table = i_cfg.use_global_table;
        o_status.out_busy     = r_out_valid && !i_ready;
        if (i_cmd.clear_step) begin
            o_status.sweep_last = (r_sweep == CNT_AW'(CNT_DEPTH - 1));
        end else begin
            o_status.sweep_last = ((r_sweep[MAX_HISTORY-1:0] & w_hmask) == w_hmask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_cmd_bit;
            r_pc    <= i_pc;
            r_tgt   <= i_resolved_target;
            r_taken <= i_taken;
            r_pdst  <= i_predicted_dest;
        end
        if (i_cmd.look && r_cmd == CMD_UPDATE) begin
            r_tgt_mem[w_idx] <= r_tgt;
            if (!w_hit) r_tag_mem[w_idx] <= w_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_cnt_mem[w_waddr] <= w_wdata;
        if (i_cmd.read) r_rdata <= r_cnt_mem[w_ci];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_reinit) begin
            r_valid  <= '0;
            r_shared <= '0;
            r_sweep  <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) r_hist[i] <= '0;
        end else begin
            if (i_cmd.clear_step || i_cmd.slice_step) begin
                r_sweep <= o_status.sweep_last ? '0 : r_sweep + CNT_AW'(1);
            end
            if (i_cmd.look && r_cmd == CMD_UPDATE && !w_hit) begin
                r_valid[w_idx] <= 1'b1;
                if (!i_cfg.use_global_history) r_hist[w_idx] <= '0;
            end
            if (i_cmd.commit && r_cmd == CMD_UPDATE) begin
                if (i_cfg.use_global_history) begin
                    r_shared <= w_new_hist;
                end else begin
                    r_hist[w_idx] <= w_new_hist;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_cmd == CMD_UPDATE) begin
                r_out_taken  <= 1'b0;
                r_out_target <= 32'd0;
                r_out_misp   <= (r_pdst != w_correct);
            end else begin
                r_out_taken  <= w_pt;
                r_out_target <= w_pt ? r_tgt_mem[w_idx] : w_seq;
                r_out_misp   <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_predict_taken  = r_out_taken;
    assign o_predict_target = r_out_target;
    assign o_mispredict     = r_out_misp;

endmodule

FILE: rtl/core/two_level_branch_predictor.sv
// Two-level branch predictor with a direct-mapped BTB of up to 32 entries and
// 8192 two-bit counters. One item is in work at a time: a predict, or an update
// that hits, goes through lookup, counter read and use; an update that misses
// with per-entry tables resets that entry's slice of 2^history_length counters
// (length held to 1..8) between lookup and counter read, one counter per cycle
// through the single counter write port. After reset and after every register
// write a clearing pass writes counter_init into all 8192 counters, during which
// no request is taken. The next request is taken while a result still waits.
// depends on tlbp_pkg, tlbp_if, tlbp_cfg, tlbp_ctrl, tlbp_dp
`timescale 1ns / 1ps

module two_level_branch_predictor
    import tlbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    tlbp_req_if.sink          i_req,
    tlbp_rsp_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg       w_cfg;
    logic       w_reinit;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_ready;

    assign i_req.ready = w_ready;

    tlbp_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (w_cfg),
        .o_reinit (w_reinit)
    );

    tlbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_reinit    (w_reinit),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tlbp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (w_cfg),
        .i_reinit          (w_reinit),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cmd_bit         (i_req.cmd),
        .i_pc              (i_req.pc),
        .i_resolved_target (i_req.resolved_target),
        .i_taken           (i_req.taken),
        .i_predicted_dest  (i_req.predicted_dest),
        .o_valid           (o_rsp.valid),
        .i_ready           (o_rsp.ready),
        .o_predict_taken   (o_rsp.predict_taken),
        .o_predict_target  (o_rsp.predict_target),
        .o_mispredict      (o_rsp.mispredict)
    );

`ifndef SYNTHESIS
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> !w_ready)
        else $error("request taken while another is in work");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result overwrites a pending transfer");

    a_reinit_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_reinit |=> !w_ready)
        else $error("request accepted during counter clearing");
`endif

endmodule
